>>> design/tbfa_pkg.sv
// Shared constants, control types and the divide-by-three helper of the alignment block.
package tbfa_pkg;

  // Largest magnitude of a narrowed mantissa
  localparam logic [31:0] MantLimit = 32'd29524;
  // Starting mark of the largest-exponent tracker
  localparam logic signed [7:0] ExpMark = -8'sd128;
  // Highest exponent value; raising saturates here
  localparam logic signed [7:0] ExpMax = 8'sd127;
  // Most divisions applied while aligning one element
  localparam int AlignLimit = 20;
  localparam int ShiftW = $clog2(AlignLimit + 1);
  // Default buffer depth
  localparam int MaxElementsDef = 64;
  // Stream payload widths
  localparam int InDataW = 40;
  localparam int OutDataW = 24;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;         // capture the accepted item
    logic step_narrow;  // one division of the working value, raise exponent
    logic step_align;   // one division of the working value, count down shift
    logic store;        // write the narrowed element, update largest exponent
    logic rd;           // read the stored element at the emit index
    logic align_init;   // set up working value and shift from the read data
    logic out_load;     // capture the aligned result into the output register
    logic next_idx;     // advance the emit index
    logic clear;        // close the vector: count, index and largest reset
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic room;         // buffer can take one more element
    logic narrow_done;  // working magnitude within the limit
    logic last;         // captured item carries the last mark
    logic align_done;   // no division left for this element
    logic final_idx;    // emit index points at the last stored element
  } sts_t;

  // Truncating division of a magnitude by three, rounded up on remainder two
  function automatic logic [31:0] div3_round(input logic [31:0] n);
    logic [63:0] prod;
    logic [31:0] quo;
    logic [31:0] rem;
    prod = {32'd0, n} * 64'h0000_0000_AAAA_AAAB;
    quo = {1'b0, prod[63:33]};
    rem = n - (quo << 1) - quo;
    if (rem[1:0] == 2'd2) begin
      quo = quo + 32'd1;
    end
    return quo;
  endfunction

endpackage

>>> design/tbfa_ctrl.sv
// Controller state machine: accept, narrow, store and emit sequencing.
module tbfa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic          s_last_i,
  input  logic          m_ready_i,
  input  tbfa_pkg::sts_t sts_i,
  output tbfa_pkg::cmd_t cmd_o,
  output logic          s_ready_o,
  output logic          m_valid_o
);
  import tbfa_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StNarrow,
    StRead,
    StAlignInit,
    StAlign,
    StOut
  } state_e;

  state_e state_q, state_d;
  logic   s_ready_q;
  logic   m_valid_q;
  logic   in_acc;
  logic   out_acc;

  assign in_acc  = s_valid_i & s_ready_q;
  assign out_acc = m_valid_q & m_ready_i;

  // Decode next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          cmd_o.load = 1'b1;
          if (sts_i.room) begin
            state_d = StNarrow;
          end else if (s_last_i) begin
            state_d = StRead;
          end
        end
      end
      StNarrow: begin
        if (sts_i.narrow_done) begin
          cmd_o.store = 1'b1;
          state_d = sts_i.last ? StRead : StIdle;
        end else begin
          cmd_o.step_narrow = 1'b1;
        end
      end
      StRead: begin
        cmd_o.rd = 1'b1;
        state_d = StAlignInit;
      end
      StAlignInit: begin
        cmd_o.align_init = 1'b1;
        state_d = StAlign;
      end
      StAlign: begin
        if (sts_i.align_done) begin
          cmd_o.out_load = 1'b1;
          state_d = StOut;
        end else begin
          cmd_o.step_align = 1'b1;
        end
      end
      StOut: begin
        if (out_acc) begin
          if (sts_i.final_idx) begin
            cmd_o.clear = 1'b1;
            state_d = StIdle;
          end else begin
            cmd_o.next_idx = 1'b1;
            state_d = StRead;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold state and the registered handshake flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      s_ready_q <= 1'b1;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      s_ready_q <= (state_d == StIdle);
      m_valid_q <= (state_d == StOut);
    end
  end

  assign s_ready_o = s_ready_q;
  assign m_valid_o = m_valid_q;

endmodule

>>> design/tbfa_dp.sv
// Datapath: shared divide-by-three unit, element buffer, exponent tracking, output register.
module tbfa_dp #(
  parameter int MAX_ELEMENTS = tbfa_pkg::MaxElementsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tbfa_pkg::InDataW-1:0]  s_data_i,
  input  logic                          s_last_i,
  input  tbfa_pkg::cmd_t                cmd_i,
  output tbfa_pkg::sts_t                sts_o,
  output logic [tbfa_pkg::OutDataW-1:0] m_data_o,
  output logic                          m_last_o
);
  import tbfa_pkg::*;

  localparam int CntW = $clog2(MAX_ELEMENTS + 1);
  localparam int IdxW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam logic signed [8:0] AlignLim9 = 9'(AlignLimit);

  // Element buffer, no reset: entries are read only after they were written
  logic [15:0]        mem_mant [MAX_ELEMENTS];
  logic signed [7:0]  mem_exp  [MAX_ELEMENTS];
  logic [15:0]        rd_mant_q;
  logic signed [7:0]  rd_exp_q;

  // Working value, shared by narrowing and alignment
  logic [31:0]        mag_q;
  logic               sign_q;
  logic signed [7:0]  exp_q;
  logic               last_q;
  logic [ShiftW-1:0]  shift_q;

  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    idx_q;
  logic signed [7:0]  largest_q;

  logic [15:0]        out_mant_q;
  logic signed [7:0]  out_exp_q;
  logic               out_last_q;

  logic signed [31:0] in_mant;
  logic signed [7:0]  in_exp;
  logic [31:0]        div_q;
  logic [15:0]        mant16;
  logic signed [7:0]  shared;
  logic [CntW-1:0]    idx_inc;
  logic               rd_neg;
  logic [15:0]        rd_mag;
  logic signed [8:0]  diff;
  logic [ShiftW-1:0]  shift_init;

  assign in_mant = $signed(s_data_i[31:0]);
  assign in_exp  = $signed(s_data_i[39:32]);
  assign div_q   = div3_round(mag_q);
  assign mant16  = sign_q ? (16'd0 - mag_q[15:0]) : mag_q[15:0];
  assign shared  = (largest_q == ExpMark) ? 8'sd0 : largest_q;
  assign idx_inc = idx_q + CntW'(1);

  // Magnitude and shift count of the element just read
  assign rd_neg = rd_mant_q[15];
  assign rd_mag = rd_neg ? (16'd0 - rd_mant_q) : rd_mant_q;
  assign diff   = {shared[7], shared} - {rd_exp_q[7], rd_exp_q};
  always_comb begin
    if (rd_mant_q == 16'd0 || diff < 9'sd0) begin
      shift_init = '0;
    end else if (diff > AlignLim9) begin
      shift_init = ShiftW'(AlignLimit);
    end else begin
      shift_init = diff[ShiftW-1:0];
    end
  end

  // Working value: load, divide, set up alignment
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sign_q <= in_mant[31];
      mag_q  <= in_mant[31] ? (32'd0 - s_data_i[31:0]) : s_data_i[31:0];
      exp_q  <= (in_mant == 32'sd0) ? 8'sd0 : in_exp;
      last_q <= s_last_i;
    end else if (cmd_i.step_narrow) begin
      mag_q <= div_q;
      if (exp_q != ExpMax) begin
        exp_q <= exp_q + 8'sd1;
      end
    end else if (cmd_i.align_init) begin
      sign_q  <= rd_neg;
      mag_q   <= {16'd0, rd_mag};
      shift_q <= shift_init;
    end else if (cmd_i.step_align) begin
      mag_q   <= div_q;
      shift_q <= shift_q - ShiftW'(1);
    end
  end

  // Write and read the element buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem_mant[count_q[IdxW-1:0]] <= mant16;
      mem_exp[count_q[IdxW-1:0]]  <= exp_q;
    end
    if (cmd_i.rd) begin
      rd_mant_q <= mem_mant[idx_q[IdxW-1:0]];
      rd_exp_q  <= mem_exp[idx_q[IdxW-1:0]];
    end
  end

  // Track fill count, emit index and largest exponent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      idx_q     <= '0;
      largest_q <= ExpMark;
    end else if (cmd_i.clear) begin
      count_q   <= '0;
      idx_q     <= '0;
      largest_q <= ExpMark;
    end else begin
      if (cmd_i.store) begin
        count_q <= count_q + CntW'(1);
        if (mag_q != 32'd0 && exp_q > largest_q) begin
          largest_q <= exp_q;
        end
      end
      if (cmd_i.next_idx) begin
        idx_q <= idx_inc;
      end
    end
  end

  // Capture the aligned result
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_mant_q <= mant16;
      out_exp_q  <= shared;
      out_last_q <= (idx_inc == count_q);
    end
  end

  assign sts_o.room        = (count_q < CntW'(MAX_ELEMENTS));
  assign sts_o.narrow_done = (mag_q <= MantLimit);
  assign sts_o.last        = last_q;
  assign sts_o.align_done  = (shift_q == '0) || (mag_q == 32'd0);
  assign sts_o.final_idx   = out_last_q;

  assign m_data_o = {out_exp_q, out_mant_q};
  assign m_last_o = out_last_q;

endmodule

>>> design/ternary_block_float_align.sv
// Top level of the base-three block floating-point alignment block.
//
// Input stream: one vector element per item, tdata holds the 32-bit signed
// mantissa and the 8-bit signed exponent, tlast marks the final element.
// Each accepted element is loaded, narrowed to magnitude 29524 or less and
// stored; narrowing takes k divisions by three, k from 0 to 11, done one a
// cycle in the shared divide unit. Elements past the buffer depth are
// dropped. On the element marked last the block emits one result per stored
// element, in order, all at the shared exponent; each result is read from
// the buffer, set up for alignment, then divided s times, s from 0 to 20,
// again one a cycle, stopping early once the value reaches zero.
// The input is not ready while narrowing or emitting. A stalled result is
// held in the output register until taken. Reset clears the element count
// and the largest exponent at once; the buffer itself needs no clearing.
module ternary_block_float_align #(
  parameter int MAX_ELEMENTS = tbfa_pkg::MaxElementsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tbfa_pkg::InDataW-1:0]  s_axis_tdata,  // mantissa_in [31:0], exponent_in [39:32]
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tbfa_pkg::OutDataW-1:0] m_axis_tdata,  // aligned_mantissa [15:0], shared_exponent [23:16]
  output logic                          m_axis_tlast
);
  import tbfa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence the work
  tbfa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid)
  );

  // Do the arithmetic and storage
  tbfa_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_data_i (s_axis_tdata),
    .s_last_i (s_axis_tlast),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .m_data_o (m_axis_tdata),
    .m_last_o (m_axis_tlast)
  );

endmodule

>>> design/tbfa_checker.sv
// Port-level checks of the alignment block, bound to its top level.
module tbfa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [tbfa_pkg::InDataW-1:0]  s_axis_tdata,
  input logic                          s_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tbfa_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);
  import tbfa_pkg::*;

  logic signed [15:0] out_mant;
  assign out_mant = $signed(m_axis_tdata[15:0]);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Input is never taken while a result is on offer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready during emission");

  // Aligned mantissa stays within the narrowed range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_mant <= 16'sd29524) && (out_mant >= -16'sd29524))
    else $error("aligned mantissa out of range");

  // Shared exponent never carries the starting mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[23:16]) != ExpMark)
    else $error("shared exponent is the starting mark");

  // The input value is not checked here
  logic unused_in;
  assign unused_in = ^{s_axis_tvalid, s_axis_tdata, s_axis_tlast};

endmodule

bind ternary_block_float_align tbfa_checker u_tbfa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
